### design/ssi_multiturn_gray_decoder_macros.svh
// Assertion macros for the SSI multiturn Gray decoder.
`ifndef SSI_MULTITURN_GRAY_DECODER_MACROS_SVH
`define SSI_MULTITURN_GRAY_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSIMTG_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssimtg assertion failed");
`define SSIMTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssimtg assertion failed");
`else
`define SSIMTG_ASSERT_IMPLIES(lbl, ante, cons)
`define SSIMTG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/ssimtg_pkg.sv
// Shared types and constants of the SSI multiturn Gray decoder.
package ssimtg_pkg;

  localparam int FrameW    = 32;
  localparam int SignBit   = 30;
  localparam int FieldW    = 30;
  localparam int PosW      = 20;
  localparam int TurnsW    = 11;
  localparam int MagW      = TurnsW - 1;
  localparam int ErrCntW   = 32;
  localparam int StW       = 5;
  localparam int MtW       = 4;
  localparam int ShiftW    = 5;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 5;

  localparam logic [StW-1:0] StMin   = StW'(2);
  localparam logic [StW-1:0] StMax   = StW'(20);
  localparam logic [StW-1:0] StReset = StW'(12);
  localparam logic [MtW-1:0] MtMin   = MtW'(2);
  localparam logic [MtW-1:0] MtMax   = MtW'(11);
  localparam logic [MtW-1:0] MtReset = MtW'(10);

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_UPDATE = 2'd0,
    ST_RESYNC = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_SINGLE_TURN_BITS = 2'd0,
    REG_MULTI_TURN_BITS  = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [PosW-1:0]          position;
    logic signed [TurnsW-1:0] turns;
  } item_t;

endpackage

### design/ssimtg_if.sv
// Valid/ready channel interfaces for SSI frames and decoded results.
interface ssimtg_in_if;
  import ssimtg_pkg::*;
  logic              valid;
  logic              ready;
  logic [FrameW-1:0] frame_word;
  modport source (output valid, output frame_word, input ready);
  modport sink (input valid, input frame_word, output ready);
endinterface

interface ssimtg_out_if;
  import ssimtg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PosW-1:0]          position;
  logic signed [TurnsW-1:0] turns;
  logic [1:0]               status;
  logic [ErrCntW-1:0]       error_count;
  modport source (output valid, output position, output turns, output status,
                  output error_count, input ready);
  modport sink (input valid, input position, input turns, input status,
                input error_count, output ready);
endinterface

### design/ssimtg_front.sv
// Front end: accepts SSI frames and Gray decodes position and turns.
module ssimtg_front (
  input  logic                    clk,
  input  logic                    rst_n,
  ssimtg_in_if.sink               in_ch,
  input  logic [ssimtg_pkg::StW-1:0] st_bits,
  input  logic [ssimtg_pkg::MtW-1:0] mt_bits,
  output logic                    req_valid,
  input  logic                    req_ready,
  output ssimtg_pkg::item_t       req_item
);
  import ssimtg_pkg::*;

  localparam int PosMaskW = PosW + 1;

  logic                     valid_r, valid_nxt;
  item_t                    item_r;
  logic [ShiftW-1:0]        shift;
  logic [FieldW-1:0]        prefix;
  logic [FieldW-1:0]        dec;
  logic [PosMaskW-1:0]      pos_mask;
  logic [MagW-1:0]          mag;
  logic [TurnsW-1:0]        turns_bits;
  item_t                    item_nxt;

  // Binary bit k of the field is the XOR of all frame bits from k up to the
  // top of the field, so the decode is a suffix XOR shifted down to the field.
  always_comb begin
    shift = ShiftW'(6'd31 - 6'(st_bits) - 6'(mt_bits));
    for (int k = 0; k < FieldW; k++) begin
      prefix[k] = ^(in_ch.frame_word[FieldW-1:0] >> k);
    end
    dec        = prefix >> shift;
    pos_mask   = (PosMaskW'(1) << st_bits) - PosMaskW'(1);
    mag        = MagW'(dec >> st_bits);
    turns_bits = in_ch.frame_word[SignBit] ? ~{1'b0, mag} : {1'b0, mag};
    item_nxt.position = dec[PosW-1:0] & pos_mask[PosW-1:0];
    item_nxt.turns    = $signed(turns_bits);
  end

  assign in_ch.ready = !valid_r || req_ready;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign req_valid = valid_r;
  assign req_item  = item_r;
endmodule

### design/ssimtg_fifo.sv
// Short queue between the decode front end and the tracking back end.
module ssimtg_fifo #(
  parameter int DEPTH = ssimtg_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ssimtg_pkg::item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ssimtg_pkg::item_t pop_item
);
  import ssimtg_pkg::*;

  localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = count_r != CountW'(DEPTH);
  assign pop_valid  = count_r != CountW'(0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? PtrW'(0) : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? PtrW'(0) : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CountW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end
endmodule

### design/ssimtg_back.sv
// Back end: turn tracking, resync and bit error counting, result register.
module ssimtg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  ssimtg_pkg::item_t pop_item,
  ssimtg_out_if.source      out_ch
);
  import ssimtg_pkg::*;

  localparam int DiffW = TurnsW + 1;
  localparam logic signed [DiffW-1:0] DiffOne = DiffW'(1);

  logic                     resync_r, resync_nxt;
  logic signed [TurnsW-1:0] last_turns_r, last_turns_nxt;
  logic [ErrCntW-1:0]       err_total_r, err_total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PosW-1:0]          position_r;
  logic signed [TurnsW-1:0] turns_r;
  status_t                  status_r, status_nxt;
  logic signed [DiffW-1:0]  diff;
  logic                     take;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    diff           = DiffW'(pop_item.turns) - DiffW'(last_turns_r);
    resync_nxt     = resync_r;
    last_turns_nxt = last_turns_r;
    err_total_nxt  = err_total_r;
    status_nxt     = ST_UPDATE;
    if (resync_r) begin
      resync_nxt     = 1'b0;
      last_turns_nxt = pop_item.turns;
      status_nxt     = ST_RESYNC;
    end else if (diff > DiffOne || diff < -DiffOne) begin
      // A jump of more than one turn cannot be real motion between frames.
      resync_nxt    = 1'b1;
      err_total_nxt = err_total_r + ErrCntW'(1);
      status_nxt    = ST_ERROR;
    end else begin
      last_turns_nxt = pop_item.turns;
    end
    out_valid_nxt = pop_ready ? pop_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_r     <= 1'b1;
      last_turns_r <= '0;
      err_total_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        resync_r     <= resync_nxt;
        last_turns_r <= last_turns_nxt;
        err_total_r  <= err_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      position_r <= pop_item.position;
      turns_r    <= pop_item.turns;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.position    = position_r;
  assign out_ch.turns       = turns_r;
  assign out_ch.status      = status_r;
  assign out_ch.error_count = err_total_r;
endmodule

### design/ssi_multiturn_gray_decoder.sv
// Path: a frame is held in the decode register, then the queue, then the result register.
// Throughput: one frame per cycle while the result side is ready; the decode register,
// a two-entry queue and the result register let both sides stall independently.
// Reset: synchronous, active low; widths go to 12 and 10 position and turn bits,
// the bit error count clears and the first frame afterwards is a resync frame.
`include "ssi_multiturn_gray_decoder_macros.svh"
module ssi_multiturn_gray_decoder #(
  parameter int QUEUE_DEPTH = ssimtg_pkg::QueueDepth
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ssimtg_in_if.sink                        in_ch,
  ssimtg_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [ssimtg_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ssimtg_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ssimtg_pkg::*;

  logic [StW-1:0] st_r, st_nxt, st_use;
  logic [MtW-1:0] mt_r, mt_nxt, mt_use;
  logic           fe_valid, fe_ready;
  item_t          fe_item;
  logic           q_valid, q_ready;
  item_t          q_item;

  always_comb begin
    st_nxt = st_r;
    mt_nxt = mt_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_SINGLE_TURN_BITS: st_nxt = cfg_wdata[StW-1:0];
        REG_MULTI_TURN_BITS:  mt_nxt = cfg_wdata[MtW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StReset;
      mt_r <= MtReset;
    end else begin
      st_r <= st_nxt;
      mt_r <= mt_nxt;
    end
  end

  // Out-of-range widths are used at the nearest limit; the stored value is kept.
  assign st_use = (st_r < StMin) ? StMin : ((st_r > StMax) ? StMax : st_r);
  assign mt_use = (mt_r < MtMin) ? MtMin : ((mt_r > MtMax) ? MtMax : mt_r);

  ssimtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .st_bits   (st_use),
    .mt_bits   (mt_use),
    .req_valid (fe_valid),
    .req_ready (fe_ready),
    .req_item  (fe_item)
  );

  ssimtg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  ssimtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item),
    .out_ch    (out_ch)
  );

  `SSIMTG_ASSERT_NEXT(a_take_loads_front, in_ch.valid && in_ch.ready, fe_valid)
  `SSIMTG_ASSERT_NEXT(a_error_then_resync, out_ch.valid && out_ch.ready && out_ch.status == ST_ERROR, !out_ch.valid || out_ch.status == ST_RESYNC)
  `SSIMTG_ASSERT_NEXT(a_err_count_step, out_ch.valid && out_ch.ready, !out_ch.valid || out_ch.error_count == $past(out_ch.error_count) || out_ch.error_count == $past(out_ch.error_count) + ErrCntW'(1))
endmodule

### tb/ssimtg_checker.sv
// Checker for the SSI multiturn Gray decoder: predicts every result and compares it.
module ssimtg_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  ssimtg_in_if                             in_ch,
  ssimtg_out_if                            out_ch,
  input  logic                             cfg_we,
  input  logic [ssimtg_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [ssimtg_pkg::CfgDataW-1:0]  cfg_wdata,
  output int unsigned                      mismatches,
  output int unsigned                      outstanding
);
  import ssimtg_pkg::*;

  typedef struct {
    logic [PosW-1:0]          position;
    logic signed [TurnsW-1:0] turns;
    status_t                  status;
    logic [ErrCntW-1:0]       error_count;
  } decoded_frame_t;

  decoded_frame_t expected_q[$];

  logic [StW-1:0]           st_reg;
  logic [MtW-1:0]           mt_reg;
  logic signed [TurnsW-1:0] last_turns;
  bit                       resync_pending;
  logic [ErrCntW-1:0]       bit_error_total;

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("%0t checker: %s", $time, what);
    mismatches++;
  endtask

  // Decodes one frame with the current widths and advances the tracking state.
  function automatic decoded_frame_t decode_frame(input logic [FrameW-1:0] frame);
    int             st;
    int             mt;
    int             mag;
    int             trn;
    int             diff;
    logic [FrameW-1:0] field;
    logic [FrameW-1:0] bin;
    decoded_frame_t r;
    st = (st_reg < StMin) ? int'(StMin) : (st_reg > StMax) ? int'(StMax) : int'(st_reg);
    mt = (mt_reg < MtMin) ? int'(MtMin) : (mt_reg > MtMax) ? int'(MtMax) : int'(mt_reg);
    field = (frame >> (FrameW - 1 - st - mt)) & ((32'd1 << (st + mt - 1)) - 32'd1);
    // Each binary bit is the parity of all Gray bits at or above it.
    bin[FrameW-1] = field[FrameW-1];
    for (int i = FrameW - 2; i >= 0; i--) bin[i] = bin[i+1] ^ field[i];
    r.position = PosW'(bin & ((32'd1 << st) - 32'd1));
    mag = int'((bin >> st) & ((32'd1 << mt) - 32'd1));
    trn = frame[SignBit] ? -mag - 1 : mag;
    r.turns = TurnsW'(trn);
    if (resync_pending) begin
      last_turns = r.turns;
      resync_pending = 1'b0;
      r.status = ST_RESYNC;
    end else begin
      diff = trn - int'(last_turns);
      if (diff > 1 || diff < -1) begin
        bit_error_total++;
        resync_pending = 1'b1;
        r.status = ST_ERROR;
      end else begin
        last_turns = r.turns;
        r.status = ST_UPDATE;
      end
    end
    r.error_count = bit_error_total;
    return r;
  endfunction

  always @(posedge clk) begin
    decoded_frame_t want;
    if (!rst_n) begin
      st_reg = StReset;
      mt_reg = MtReset;
      last_turns = '0;
      resync_pending = 1'b1;
      bit_error_total = '0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      // Results are retired before new requests are queued, so one that appears
      // with nothing outstanding is caught even if a frame is taken at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with no frame outstanding, position %0h",
                                    out_ch.position));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.position !== want.position)
            report_mismatch($sformatf("position got %0h expected %0h",
                                      out_ch.position, want.position));
          if (out_ch.turns !== want.turns)
            report_mismatch($sformatf("turns got %0d expected %0d",
                                      out_ch.turns, want.turns));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.error_count !== want.error_count)
            report_mismatch($sformatf("error count got %0d expected %0d",
                                      out_ch.error_count, want.error_count));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SINGLE_TURN_BITS: st_reg = cfg_wdata[StW-1:0];
          REG_MULTI_TURN_BITS:  mt_reg = cfg_wdata[MtW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) expected_q.push_back(decode_frame(in_ch.frame_word));
    end
    outstanding = expected_q.size();
  end

endmodule

### tb/tb_ssi_multiturn_gray_decoder.sv
// Top of the SSI multiturn Gray decoder testbench: clock, reset, stimulus and verdict.
module tb_ssi_multiturn_gray_decoder;
  import ssimtg_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 150;
  localparam int HoldAfter  = 500;
  localparam int HoldCycles = 300;
  localparam int IdlePct    = 13;
  localparam logic [CfgIndexW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;
  int unsigned          mismatches;
  int unsigned          outstanding;

  int          eff_st;
  int          eff_mt;
  int          walk_turns;
  bit          calm;
  int unsigned frames_sent;
  int unsigned cycles;

  ssimtg_in_if  in_if ();
  ssimtg_out_if out_if ();

  ssi_multiturn_gray_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssimtg_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus one long hold-off that backs the decoder up.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && frames_sent >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Builds a frame carrying the given position and turns at the current widths;
  // the bits outside the field, but for the sign bit, are random.
  function automatic logic [FrameW-1:0] build_frame(input int pos, input int trn);
    int                shift;
    int                mag;
    logic [FrameW-1:0] bin;
    logic [FrameW-1:0] field_mask;
    logic [FrameW-1:0] frame;
    shift = FrameW - 1 - eff_st - eff_mt;
    mag = (trn < 0) ? -trn - 1 : trn;
    bin = (32'(mag) << eff_st) | (32'(pos) & ((32'd1 << eff_st) - 32'd1));
    field_mask = ((32'd1 << (eff_st + eff_mt - 1)) - 32'd1) << shift;
    frame = $urandom() & ~field_mask & ~(32'd1 << SignBit);
    frame |= ((bin ^ (bin >> 1)) << shift) & field_mask;
    if (trn < 0) frame |= 32'd1 << SignBit;
    return frame;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows the acceptance of the request.
  task automatic send_frame(input logic [FrameW-1:0] frame);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.frame_word <= frame;
    do @(posedge clk); while (!in_if.ready);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_widths(input logic [CfgDataW-1:0] st_val, input logic [CfgDataW-1:0] mt_val);
    logic [MtW-1:0] mt_field;
    settle();
    write_reg(REG_SINGLE_TURN_BITS, st_val);
    write_reg(REG_MULTI_TURN_BITS, mt_val);
    // A write to an unused index must leave both widths alone.
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CfgDataW'($urandom()));
    mt_field = mt_val[MtW-1:0];
    eff_st = (st_val < StMin) ? int'(StMin) : (st_val > StMax) ? int'(StMax) : int'(st_val);
    eff_mt = (mt_field < MtMin) ? int'(MtMin) : (mt_field > MtMax) ? int'(MtMax) : int'(mt_field);
  endtask

  // Mostly a random walk of turns that never jumps by more than one, with
  // deliberate jumps and raw noise mixed in.
  task automatic random_items(input int count);
    int pick;
    int pos;
    int trn;
    int tmin;
    int tmax;
    int pmax;
    tmax = (1 << (eff_mt - 1)) - 1;
    tmin = -(1 << (eff_mt - 1));
    pmax = (1 << eff_st) - 1;
    walk_turns = $urandom_range(0, 1) ? tmax : tmin;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      pos = $urandom_range(0, pmax);
      if ($urandom_range(0, 9) == 0) pos = 0;
      else if ($urandom_range(0, 9) == 0) pos = pmax;
      if (pick < 78) begin
        walk_turns += int'($urandom_range(0, 2)) - 1;
        if (walk_turns > tmax) walk_turns = tmax;
        if (walk_turns < tmin) walk_turns = tmin;
        send_frame(build_frame(pos, walk_turns));
      end else if (pick < 90) begin
        do trn = int'($urandom_range(0, tmax - tmin)) + tmin;
        while (trn - walk_turns < 2 && walk_turns - trn < 2);
        send_frame(build_frame(pos, trn));
      end else begin
        send_frame($urandom());
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SINGLE_TURN_BITS;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.frame_word = '0;
    calm = 1'b0;
    frames_sent = 0;
    eff_st = StReset;
    eff_mt = MtReset;
    walk_turns = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at the reset widths: raw extremes first, then a sequence
    // through updates, a turn jump, the resync after it and the turn extremes.
    send_frame(32'h0000_0000);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);
    send_frame(32'h4000_0000);
    send_frame(32'h8000_0000);
    send_frame(32'h7FFF_FFFF);
    send_frame(32'hBFFF_FFFF);
    send_frame(32'h3FFF_FFFF);
    send_frame(build_frame(0, 0));
    send_frame(build_frame(0, 0));
    send_frame(build_frame(4095, 1));
    send_frame(build_frame(4095, 0));
    send_frame(build_frame(0, -1));
    send_frame(build_frame(5, -2));
    send_frame(build_frame(0, 0));
    send_frame(build_frame(4095, 511));
    send_frame(build_frame(0, 510));
    send_frame(build_frame(0, -512));
    send_frame(build_frame(0, -512));
    send_frame(build_frame(4095, -511));
    send_frame(build_frame(1, -512));

    set_widths(5'd2, 5'd2);
    random_items(PhaseItems);
    set_widths(5'd20, 5'd11);
    random_items(PhaseItems);
    set_widths(5'd0, 5'd1);
    random_items(PhaseItems);
    set_widths(5'd31, 5'd15);
    random_items(PhaseItems);
    set_widths(5'd2, 5'd11);
    random_items(PhaseItems);
    set_widths(5'd20, 5'd2);
    random_items(PhaseItems);
    calm <= 1'b1;
    set_widths(5'd12, 5'd10);
    random_items(PhaseItems);
    calm <= 1'b0;
    // Bit 4 of the data is not part of the turn-bits register.
    set_widths(5'd16, 5'b10011);
    random_items(PhaseItems);
    set_widths(CfgDataW'($urandom_range(0, 31)), CfgDataW'($urandom_range(0, 31)));
    random_items(PhaseItems);

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
